// ----- sv/quaternion_axis_angle_rotate_top_defines.svh -----
// Assertion macros shared by the rotate block
`ifndef QUATERNION_AXIS_ANGLE_ROTATE_TOP_DEFINES_SVH
`define QUATERNION_AXIS_ANGLE_ROTATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define QAAR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qaar assertion failed");
`define QAAR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qaar assertion failed");
`else
`define QAAR_ASSERT(lbl, clk, rst_n, prop)
`define QAAR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/qaar_pkg.sv -----
package qaar_pkg;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [23:0] turn_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] z;
        logic               neg_cos;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_work_item;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam int MAG_W  = 35;
    localparam int CORD_W = 34;

    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;
    localparam logic signed [CORD_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [31:0] INT32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

    function automatic logic [MAG_W-1:0] two_pi_mult(input logic [3:0] k);
        logic [MAG_W-1:0] v;
        case (k)
            4'd1:    v = 35'd1686629713;
            4'd2:    v = 35'd3373259426;
            4'd3:    v = 35'd5059889139;
            4'd4:    v = 35'd6746518852;
            4'd5:    v = 35'd8433148565;
            4'd6:    v = 35'd10119778278;
            4'd7:    v = 35'd11806407991;
            4'd8:    v = 35'd13493037704;
            4'd9:    v = 35'd15179667417;
            4'd10:   v = 35'd16866297130;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] atan_q28(input int i);
        logic signed [31:0] v;
        case (i)
            0:       v = 32'sd210828714;
            1:       v = 32'sd124459457;
            2:       v = 32'sd65760959;
            3:       v = 32'sd33381290;
            4:       v = 32'sd16755422;
            5:       v = 32'sd8385879;
            6:       v = 32'sd4193963;
            7:       v = 32'sd2097109;
            8:       v = 32'sd1048571;
            9:       v = 32'sd524287;
            default: v = 32'sd268435456 >>> i;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/qaar_front.sv -----
module qaar_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  qaar_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output qaar_pkg::t_work_item  o_item
);

    logic                          r_v1, r_v2;
    logic [qaar_pkg::MAG_W-1:0]    r_mag, n_mag;
    logic                          r_neg, n_neg;
    logic [3:0]                    r_k, n_k;
    qaar_pkg::t_in_item            r_in;
    qaar_pkg::t_work_item          r_work, n_work;
    logic                          adv;

    assign adv     = !r_v2 || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v2;
    assign o_item  = r_work;

    always_comb begin
        logic signed [qaar_pkg::MAG_W-1:0] a;
        a     = {i_item.turn_angle, 11'd0};
        n_neg = a[qaar_pkg::MAG_W-1];
        n_mag = n_neg ? (qaar_pkg::MAG_W)'(-a) : (qaar_pkg::MAG_W)'(a);
        n_k   = '0;
        for (int k = 1; k <= 10; k++) begin
            if (n_mag >= qaar_pkg::two_pi_mult(4'(k))) begin
                n_k = n_k + 4'd1;
            end
        end
    end

    always_comb begin
        logic [qaar_pkg::MAG_W-1:0] rm;
        logic signed [31:0]         r;
        rm = r_mag - qaar_pkg::two_pi_mult(r_k);
        r  = r_neg ? -$signed({1'b0, rm[30:0]}) : $signed({1'b0, rm[30:0]});
        if (r > qaar_pkg::PI_Q28) begin
            r = r - qaar_pkg::TWO_PI_Q28;
        end
        if (r < -qaar_pkg::PI_Q28) begin
            r = r + qaar_pkg::TWO_PI_Q28;
        end
        n_work.neg_cos = 1'b0;
        if (r > qaar_pkg::HALF_PI_Q28) begin
            r = qaar_pkg::PI_Q28 - r;
            n_work.neg_cos = 1'b1;
        end else if (r < -qaar_pkg::HALF_PI_Q28) begin
            r = -qaar_pkg::PI_Q28 - r;
            n_work.neg_cos = 1'b1;
        end
        n_work.z      = r;
        n_work.dir_x  = r_in.dir_x;
        n_work.dir_y  = r_in.dir_y;
        n_work.dir_z  = r_in.dir_z;
        n_work.axis_x = r_in.axis_x;
        n_work.axis_y = r_in.axis_y;
        n_work.axis_z = r_in.axis_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mag  <= n_mag;
            r_neg  <= n_neg;
            r_k    <= n_k;
            r_in   <= i_item;
            r_work <= n_work;
        end
    end

endmodule

// ----- sv/qaar_queue.sv -----
`include "quaternion_axis_angle_rotate_top_defines.svh"

module qaar_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  qaar_pkg::t_work_item  i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output qaar_pkg::t_work_item  o_item
);

    qaar_pkg::t_work_item                r_mem [qaar_pkg::QUEUE_DEPTH];
    logic [qaar_pkg::QUEUE_PTR_W-1:0]    r_wr, r_rd;
    logic [qaar_pkg::QUEUE_CNT_W-1:0]    r_count;
    logic                                push, pop;

    assign o_ready = r_count != qaar_pkg::QUEUE_CNT_W'(qaar_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `QAAR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= qaar_pkg::QUEUE_CNT_W'(qaar_pkg::QUEUE_DEPTH))
    `QAAR_ASSERT(a_count_up, i_clk, i_rst_n, (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
    `QAAR_ASSERT(a_count_down, i_clk, i_rst_n, (pop && !push) |=> (r_count == $past(r_count) - 1'b1))
    `QAAR_ASSERT(a_ptr_gap, i_clk, i_rst_n, (r_count == '0) |-> (r_wr == r_rd))

endmodule

// ----- sv/qaar_back.sv -----
module qaar_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  qaar_pkg::t_work_item  i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output qaar_pkg::t_out_item   o_item
);

    localparam int N = CORDIC_STEPS;
    localparam int W = qaar_pkg::CORD_W;

    logic                 adv;
    logic                 r_cv [N+1];
    logic signed [W-1:0]  r_x  [N+1];
    logic signed [W-1:0]  r_y  [N+1];
    logic signed [31:0]   r_z  [N+1];
    qaar_pkg::t_work_item r_w  [N+1];

    logic                 r_vq, r_vm1, r_vs1, r_vm2, r_vo;
    logic signed [27:0]   r_qw, r_qx, r_qy, r_qz;
    logic signed [31:0]   r_dx, r_dy, r_dz;
    logic signed [59:0]   r_m1 [12];
    logic signed [27:0]   r_qw1, r_qx1, r_qy1, r_qz1;
    logic signed [35:0]   r_pw, r_px, r_py, r_pz;
    logic signed [27:0]   r_qw2, r_qx2, r_qy2, r_qz2;
    logic signed [63:0]   r_m2 [12];
    qaar_pkg::t_out_item  r_out, n_out;
    logic signed [W-1:0]  cs;

    assign adv     = !r_vo || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vo;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (adv) begin
            r_cv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x[0] <= qaar_pkg::INV_GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= i_item.z;
            r_w[0] <= i_item;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (adv) begin
                r_cv[i+1] <= r_cv[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_w[i+1] <= r_w[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - qaar_pkg::atan_q28(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + qaar_pkg::atan_q28(i);
                end
            end
        end
    end

    assign cs = r_w[N].neg_cos ? -r_x[N] : r_x[N];

    always_comb begin
        logic signed [65:0] sx, sy, sz;
        logic signed [41:0] rx, ry, rz;
        sx = 66'(r_m2[0]) - 66'(r_m2[1]) - 66'(r_m2[2]) + 66'(r_m2[3]) + 66'sd8388608;
        sy = 66'(r_m2[4]) - 66'(r_m2[5]) - 66'(r_m2[6]) + 66'(r_m2[7]) + 66'sd8388608;
        sz = 66'(r_m2[8]) - 66'(r_m2[9]) - 66'(r_m2[10]) + 66'(r_m2[11]) + 66'sd8388608;
        rx = 42'(sx >>> 24);
        ry = 42'(sy >>> 24);
        rz = 42'(sz >>> 24);
        n_out.saturated = 1'b0;
        if (rx > 42'(qaar_pkg::INT32_MAX)) begin
            n_out.out_x = qaar_pkg::INT32_MAX;
            n_out.saturated = 1'b1;
        end else if (rx < 42'(qaar_pkg::INT32_MIN)) begin
            n_out.out_x = qaar_pkg::INT32_MIN;
            n_out.saturated = 1'b1;
        end else begin
            n_out.out_x = 32'(rx);
        end
        if (ry > 42'(qaar_pkg::INT32_MAX)) begin
            n_out.out_y = qaar_pkg::INT32_MAX;
            n_out.saturated = 1'b1;
        end else if (ry < 42'(qaar_pkg::INT32_MIN)) begin
            n_out.out_y = qaar_pkg::INT32_MIN;
            n_out.saturated = 1'b1;
        end else begin
            n_out.out_y = 32'(ry);
        end
        if (rz > 42'(qaar_pkg::INT32_MAX)) begin
            n_out.out_z = qaar_pkg::INT32_MAX;
            n_out.saturated = 1'b1;
        end else if (rz < 42'(qaar_pkg::INT32_MIN)) begin
            n_out.out_z = qaar_pkg::INT32_MIN;
            n_out.saturated = 1'b1;
        end else begin
            n_out.out_z = 32'(rz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq  <= 1'b0;
            r_vm1 <= 1'b0;
            r_vs1 <= 1'b0;
            r_vm2 <= 1'b0;
            r_vo  <= 1'b0;
        end else if (adv) begin
            r_vq  <= r_cv[N];
            r_vm1 <= r_vq;
            r_vs1 <= r_vm1;
            r_vm2 <= r_vs1;
            r_vo  <= r_vm2;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [49:0] px, py, pz;
        logic signed [63:0] sw, sx, sy, sz;
        if (adv) begin
            px = 50'(r_y[N]) * 50'(r_w[N].axis_x);
            py = 50'(r_y[N]) * 50'(r_w[N].axis_y);
            pz = 50'(r_y[N]) * 50'(r_w[N].axis_z);
            r_qw <= 28'((cs + W'(32)) >>> 6);
            r_qx <= 28'((px + 50'sd524288) >>> 20);
            r_qy <= 28'((py + 50'sd524288) >>> 20);
            r_qz <= 28'((pz + 50'sd524288) >>> 20);
            r_dx <= r_w[N].dir_x;
            r_dy <= r_w[N].dir_y;
            r_dz <= r_w[N].dir_z;

            r_m1[0]  <= 60'(r_qx) * 60'(r_dx);
            r_m1[1]  <= 60'(r_qy) * 60'(r_dy);
            r_m1[2]  <= 60'(r_qz) * 60'(r_dz);
            r_m1[3]  <= 60'(r_qw) * 60'(r_dx);
            r_m1[4]  <= 60'(r_qy) * 60'(r_dz);
            r_m1[5]  <= 60'(r_qz) * 60'(r_dy);
            r_m1[6]  <= 60'(r_qw) * 60'(r_dy);
            r_m1[7]  <= 60'(r_qz) * 60'(r_dx);
            r_m1[8]  <= 60'(r_qx) * 60'(r_dz);
            r_m1[9]  <= 60'(r_qw) * 60'(r_dz);
            r_m1[10] <= 60'(r_qx) * 60'(r_dy);
            r_m1[11] <= 60'(r_qy) * 60'(r_dx);
            r_qw1 <= r_qw;
            r_qx1 <= r_qx;
            r_qy1 <= r_qy;
            r_qz1 <= r_qz;

            sw = -64'(r_m1[0]) - 64'(r_m1[1]) - 64'(r_m1[2]) + 64'sd8388608;
            sx = 64'(r_m1[3]) + 64'(r_m1[4]) - 64'(r_m1[5]) + 64'sd8388608;
            sy = 64'(r_m1[6]) + 64'(r_m1[7]) - 64'(r_m1[8]) + 64'sd8388608;
            sz = 64'(r_m1[9]) + 64'(r_m1[10]) - 64'(r_m1[11]) + 64'sd8388608;
            r_pw <= 36'(sw >>> 24);
            r_px <= 36'(sx >>> 24);
            r_py <= 36'(sy >>> 24);
            r_pz <= 36'(sz >>> 24);
            r_qw2 <= r_qw1;
            r_qx2 <= r_qx1;
            r_qy2 <= r_qy1;
            r_qz2 <= r_qz1;

            r_m2[0]  <= 64'(r_px) * 64'(r_qw2);
            r_m2[1]  <= 64'(r_pw) * 64'(r_qx2);
            r_m2[2]  <= 64'(r_py) * 64'(r_qz2);
            r_m2[3]  <= 64'(r_pz) * 64'(r_qy2);
            r_m2[4]  <= 64'(r_py) * 64'(r_qw2);
            r_m2[5]  <= 64'(r_pw) * 64'(r_qy2);
            r_m2[6]  <= 64'(r_pz) * 64'(r_qx2);
            r_m2[7]  <= 64'(r_px) * 64'(r_qz2);
            r_m2[8]  <= 64'(r_pz) * 64'(r_qw2);
            r_m2[9]  <= 64'(r_pw) * 64'(r_qz2);
            r_m2[10] <= 64'(r_px) * 64'(r_qy2);
            r_m2[11] <= 64'(r_py) * 64'(r_qx2);

            r_out <= n_out;
        end
    end

endmodule

// ----- sv/quaternion_axis_angle_rotate_top.sv -----
// Rotates a Q16.16 direction about a Q2.14 axis by a Q8.16 angle, q*v*conj(q),
// with saturation of each component. One item is accepted per clock cycle
// while o_ready is high. From input to output an item passes the angle
// reduction and folding registers, the queue, the CORDIC load register and
// one CORDIC stage per step, and the stages that form the quaternion and
// take the two quaternion products. The four-entry queue lets the angle
// front end keep accepting while the output is held, until the queue fills.
module quaternion_axis_angle_rotate_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  qaar_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output qaar_pkg::t_out_item  o_item
);

    logic                 f_valid, f_ready, q_valid, q_ready;
    qaar_pkg::t_work_item f_item, q_item;

    qaar_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    qaar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    qaar_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule
